// File: rtl/core/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// shared types, codes and character helpers for the integer to ascii
// formatter
// ----------------------------------------------------------------------------
`default_nettype none

package i2a_pkg;

    // format kinds
    localparam logic [1:0] KIND_HEX  = 2'd0;
    localparam logic [1:0] KIND_UDEC = 2'd1;
    localparam logic [1:0] KIND_SDEC = 2'd2;

    // operand and digit geometry
    localparam int VALUE_W    = 32;
    localparam int DIGITS     = 10;
    localparam int NIBBLE_CNT = 8;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = 4;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_W - 1);
    localparam logic [IDX_W-1:0] HEX_TOP   = IDX_W'(NIBBLE_CNT - 1);

    // ascii codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_A_OFS = 8'h57;

    typedef logic [DIGITS-1:0][3:0] digits_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    // control into the conversion unit
    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] mag;
    } conv_ctrl_t;

    // status out of the conversion unit
    typedef struct packed {
        logic busy;
        logic done;
    } conv_stat_t;

    // one nibble to its lowercase hex character
    function automatic logic [7:0] nibble_char(input logic [3:0] nib);
        logic [7:0] code;
        if (nib < 4'd10)
        begin
            code = CHAR_ZERO + {4'h0, nib};
        end
        else
        begin
            code = CHAR_A_OFS + {4'h0, nib};
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/i2a_operand_if.sv
// ----------------------------------------------------------------------------
// i2a_operand_if
// request channel carrying a format kind and a 32-bit value
// ----------------------------------------------------------------------------
`default_nettype none

interface i2a_operand_if;
    import i2a_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);

endinterface

`default_nettype wire

// File: rtl/core/i2a_text_if.sv
// ----------------------------------------------------------------------------
// i2a_text_if
// character channel, one ascii character per request with an end marker
// ----------------------------------------------------------------------------
`default_nettype none

interface i2a_text_if;

    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last;

    modport source (output valid, output char_out, output last, input ready);
    modport sink   (input valid, input char_out, input last, output ready);

endinterface

`default_nettype wire

// File: rtl/core/i2a_conv.sv
// ----------------------------------------------------------------------------
// i2a_conv
// iterative binary to bcd converter, shift and add-3, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_conv (
    input  wire                  clk,
    input  wire                  rst_n,
    input  i2a_pkg::conv_ctrl_t  ctrl,
    output i2a_pkg::conv_stat_t  stat,
    output i2a_pkg::digits_t     bcd
);
    import i2a_pkg::*;

    logic [VALUE_W-1:0] bin_reg;
    logic [VALUE_W-1:0] bin_next;
    digits_t            bcd_reg;
    digits_t            bcd_next;
    digits_t            adj;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    // add-3 correction on every digit, then shift one bit in
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? (bcd_reg[i] + 4'd3) : bcd_reg[i];
        end
        {bcd_next, bin_next} = {adj, bin_reg} << 1;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            bin_reg <= ctrl.mag;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

    // step counter and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign bcd       = bcd_reg;

    // a running conversion keeps going until its final step
    a_busy_holds: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (cnt_reg != LAST_STEP) |=> busy_reg)
        else $error("conversion stopped early");

    // done comes only right after the final step
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && ($past(cnt_reg) == LAST_STEP))
        else $error("done without final step");

endmodule

`default_nettype wire

// File: rtl/core/integer_to_ascii_formatter_top.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// formats a 32-bit value as hex, unsigned decimal or signed decimal ascii
// ----------------------------------------------------------------------------
//  channel   dir   payload             one request is
//  operand   in    kind, value         one number to format
//  text      out   char_out, last      one character, last marks run end
//
//  hex: the value is loaded, then 8 characters go out one per cycle unless text stalls
//  decimal: the value is loaded, the shift/add-3 converter steps through all 32 bits,
//  the leading digit is picked as it finishes, then up to 11 characters one per cycle unless text stalls
//  operand.ready is high only while idle; kind 3 is taken and dropped
//  a stalled text channel holds the emitter; the final character sits in the
//  output register while the next operand is taken
//  reset clears all control state, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_formatter_top (
    input  wire             clk,
    input  wire             rst_n,
    i2a_operand_if.sink     operand,
    i2a_text_if.source      text
);
    import i2a_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    digits_t          digit_reg;
    digits_t          digit_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             sign_reg;
    logic             sign_next;
    logic             out_valid_reg;
    logic [7:0]       char_reg;
    logic             last_reg;

    conv_ctrl_t       conv_ctrl;
    conv_stat_t       conv_stat;
    digits_t          conv_bcd;
    logic [IDX_W-1:0] lead_idx;
    logic             in_fire;
    logic             emit_fire;
    logic [7:0]       emit_char;
    logic             emit_last;

    // conversion unit shared by the two decimal kinds
    i2a_conv u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (conv_ctrl),
        .stat  (conv_stat),
        .bcd   (conv_bcd)
    );

    assign operand.ready = (state_reg == ST_IDLE);
    assign in_fire       = operand.valid && operand.ready;
    assign emit_fire     = (state_reg == ST_EMIT) && (!out_valid_reg || text.ready);

    // leading nonzero digit of the converted value
    always_comb
    begin
        lead_idx = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (conv_bcd[i] != 4'd0)
            begin
                lead_idx = IDX_W'(i);
            end
        end
    end

    // character under the emit pointer
    always_comb
    begin
        emit_char = sign_reg ? CHAR_MINUS : nibble_char(digit_reg[idx_reg]);
        emit_last = !sign_reg && (idx_reg == '0);
    end

    // conversion start and magnitude
    always_comb
    begin
        conv_ctrl.start = 1'b0;
        conv_ctrl.mag   = operand.value;
        if (operand.kind == KIND_SDEC && operand.value[VALUE_W-1])
        begin
            conv_ctrl.mag = ~operand.value + 1'b1;
        end
        if (in_fire && (operand.kind == KIND_UDEC || operand.kind == KIND_SDEC))
        begin
            conv_ctrl.start = 1'b1;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        digit_next = digit_reg;
        idx_next   = idx_reg;
        sign_next  = sign_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (operand.kind)
                        KIND_HEX:
                        begin
                            digit_next = digits_t'({8'h00, operand.value});
                            idx_next   = HEX_TOP;
                            sign_next  = 1'b0;
                            state_next = ST_EMIT;
                        end
                        KIND_UDEC:
                        begin
                            sign_next  = 1'b0;
                            state_next = ST_CONV;
                        end
                        KIND_SDEC:
                        begin
                            sign_next  = operand.value[VALUE_W-1];
                            state_next = ST_CONV;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                if (conv_stat.done)
                begin
                    digit_next = conv_bcd;
                    idx_next   = lead_idx;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    if (sign_reg)
                    begin
                        sign_next = 1'b0;
                    end
                    else if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sign_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sign_reg  <= sign_next;
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (text.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
        idx_reg   <= idx_next;
        if (emit_fire)
        begin
            char_reg <= emit_char;
            last_reg <= emit_last;
        end
    end

    assign text.valid    = out_valid_reg;
    assign text.char_out = char_reg;
    assign text.last     = last_reg;

    // the converter only runs while the sequencer waits on it
    a_conv_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        conv_stat.busy || conv_stat.done |-> state_reg == ST_CONV)
        else $error("converter active outside conversion state");

    // the sign character is never the end of a run
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire && sign_reg |=> out_valid_reg && !last_reg)
        else $error("sign marked as last character");

    // leaving emission always follows a last character
    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && state_next == ST_IDLE |=> out_valid_reg && last_reg)
        else $error("run ended without last marker");

endmodule

`default_nettype wire

// File: bench/tb_integer_to_ascii_formatter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter_top
// self-checking bench for the integer to ascii formatter: drives hex,
// unsigned and signed decimal numbers plus the unused kind, predicts each
// character run in a scoreboard and compares every character and end marker,
// under several patterns of sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter_top;
    import i2a_pkg::*;

    // kind with no output, taken and dropped by the block
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PER_PHASE = 55;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_beat_t;

    // expected character runs, oldest first
    class number_text_scoreboard;
        text_beat_t expected_text[$];
        int         mismatches;
        int         chars_checked;
        int         numbers_by_kind[4];

        function new();
            mismatches = 0;
            chars_checked = 0;
            foreach (numbers_by_kind[i])
            begin
                numbers_by_kind[i] = 0;
            end
        endfunction

        // predict the run for one accepted request and queue it
        function void note_number(logic [1:0] kind, logic [31:0] value);
            string       hex_glyphs;
            logic [7:0]  run [0:10];
            logic [7:0]  rev [0:9];
            logic [31:0] mag;
            int          len;
            int          cnt;
            text_beat_t  beat;
            hex_glyphs = "0123456789abcdef";
            len = 0;
            cnt = 0;
            numbers_by_kind[kind]++;
            if (kind == KIND_HEX)
            begin
                for (int sh = 28; sh >= 0; sh -= 4)
                begin
                    run[len] = hex_glyphs[value[sh +: 4]];
                    len++;
                end
            end
            else if (kind == KIND_UDEC || kind == KIND_SDEC)
            begin
                mag = value;
                if (kind == KIND_SDEC && value[31])
                begin
                    run[len] = "-";
                    len++;
                    mag = ~value + 32'd1;
                end
                if (mag == 32'd0)
                begin
                    run[len] = "0";
                    len++;
                end
                // digits come out least significant first
                while (mag != 32'd0)
                begin
                    rev[cnt] = 8'h30 + 8'(mag % 32'd10);
                    mag = mag / 32'd10;
                    cnt++;
                end
                while (cnt > 0)
                begin
                    cnt--;
                    run[len] = rev[cnt];
                    len++;
                end
            end
            for (int k = 0; k < len; k++)
            begin
                beat.ch = run[k];
                beat.last = (k == len - 1);
                expected_text.push_back(beat);
            end
        endfunction

        // compare one accepted character with the oldest expectation
        function void check_char(logic [7:0] ch, logic last);
            text_beat_t want;
            if (expected_text.size() == 0)
            begin
                $error("unexpected character: char_out actual %h last actual %b", ch, last);
                mismatches++;
            end
            else
            begin
                want = expected_text.pop_front();
                chars_checked++;
                if (ch !== want.ch)
                begin
                    $error("char_out mismatch: expected %h actual %h", want.ch, ch);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last mismatch: expected %b actual %b", want.last, last);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return expected_text.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   quiet_cycles;

    number_text_scoreboard text_sb = new();

    i2a_operand_if operand_ch ();
    i2a_text_if    text_ch ();

    integer_to_ascii_formatter_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand_ch),
        .text    (text_ch)
    );

    // clock
    always #2 clk = ~clk;

    // receiver back-pressure
    always @(posedge clk)
    begin
        text_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // character checker
    always @(posedge clk)
    begin
        if (rst_n && text_ch.valid && text_ch.ready)
        begin
            text_sb.check_char(text_ch.char_out, text_ch.last);
        end
    end

    // watchdog on cycles with no request moving on either channel
    always @(posedge clk)
    begin
        if ((operand_ch.valid && operand_ch.ready) || (text_ch.valid && text_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL integer_to_ascii_formatter_top");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one number and hold it until taken
    task automatic send_number(input logic [1:0] kind, input logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            operand_ch.valid <= 1'b0;
            @(posedge clk);
        end
        operand_ch.valid <= 1'b1;
        operand_ch.kind  <= kind;
        operand_ch.value <= value;
        @(posedge clk);
        while (!operand_ch.ready)
        begin
            @(posedge clk);
        end
        text_sb.note_number(kind, value);
    endtask

    // sender holds off until every queued character has come out
    task automatic drain_text();
        operand_ch.valid <= 1'b0;
        @(posedge clk);
        while (text_sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // random mix of kinds and values aimed at digit-count boundaries
    task automatic random_phase(input int count);
        logic [31:0] pow10 [0:9];
        logic [31:0] value;
        logic [1:0]  kind;
        int          pick;
        pow10[0] = 32'd1;
        for (int i = 1; i < 10; i++)
        begin
            pow10[i] = pow10[i-1] * 32'd10;
        end
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(19);
            kind = (pick == 0) ? KIND_NONE : 2'(pick % 3);
            case ($urandom_range(4))
                0: value = $urandom_range(99);
                1: value = pow10[$urandom_range(9)] + $urandom_range(2) - 1;
                2: value = 32'd0 - $urandom_range(1000);
                3: value = {1'b1, 31'($urandom())};
                default: value = $urandom();
            endcase
            send_number(kind, value);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        operand_ch.valid = 1'b0;
        operand_ch.kind = KIND_HEX;
        operand_ch.value = 32'd0;
        text_ch.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every kind, zero, most negative, unused kind
        send_number(KIND_HEX, 32'h0000_0000);
        send_number(KIND_HEX, 32'hffff_ffff);
        send_number(KIND_HEX, 32'h0123_4567);
        send_number(KIND_HEX, 32'h89ab_cdef);
        send_number(KIND_HEX, 32'ha5a5_5a5a);
        send_number(KIND_UDEC, 32'd0);
        send_number(KIND_UDEC, 32'hffff_ffff);
        send_number(KIND_UDEC, 32'd1);
        send_number(KIND_UDEC, 32'd9);
        send_number(KIND_UDEC, 32'd10);
        send_number(KIND_UDEC, 32'd1000000000);
        send_number(KIND_UDEC, 32'h8000_0000);
        send_number(KIND_SDEC, 32'd0);
        send_number(KIND_SDEC, 32'h8000_0000);
        send_number(KIND_SDEC, 32'hffff_ffff);
        send_number(KIND_SDEC, 32'h7fff_ffff);
        send_number(KIND_SDEC, 32'hffff_fff6);
        send_number(KIND_SDEC, 32'd5);
        send_number(KIND_SDEC, 32'd12345);
        send_number(KIND_NONE, 32'hdead_beef);
        send_number(KIND_NONE, 32'h0000_0000);
        send_number(KIND_UDEC, 32'd42);
        drain_text();

        // random phases under different gap patterns
        random_phase(RANDOM_PER_PHASE);
        drain_text();
        send_idle_pct = 78;
        random_phase(RANDOM_PER_PHASE);
        drain_text();
        send_idle_pct = 0;
        recv_stall_pct = 78;
        random_phase(RANDOM_PER_PHASE);
        drain_text();
        send_idle_pct = 30;
        recv_stall_pct = 30;
        random_phase(RANDOM_PER_PHASE);

        // let stragglers show up
        drain_text();
        repeat (60) @(posedge clk);
        if (text_sb.pending() != 0)
        begin
            $error("characters never arrived: %0d still expected", text_sb.pending());
            text_sb.mismatches++;
        end

        $display("covered %0d hex, %0d unsigned, %0d signed and %0d dropped numbers",
                 text_sb.numbers_by_kind[KIND_HEX], text_sb.numbers_by_kind[KIND_UDEC],
                 text_sb.numbers_by_kind[KIND_SDEC], text_sb.numbers_by_kind[KIND_NONE]);
        $display("%0d characters checked, %0d mismatches",
                 text_sb.chars_checked, text_sb.mismatches);
        if (text_sb.mismatches == 0)
        begin
            $display("PASS integer_to_ascii_formatter_top");
        end
        else
        begin
            $display("FAIL integer_to_ascii_formatter_top");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/i2a_pkg.sv
rtl/core/i2a_operand_if.sv
rtl/core/i2a_text_if.sv
rtl/core/i2a_conv.sv
rtl/core/integer_to_ascii_formatter_top.sv
bench/tb_integer_to_ascii_formatter_top.sv
